FILE: rtl/lvd_pkg.sv
// Package for the logarithmic video detector: shared types, fixed-point constants
// and the elaboration-time functions that fill the log2 and sine tables.
// No dependencies.
package lvd_pkg;

   // Width of a log2 result in unsigned Q16 (integer part up to 31).
   localparam int LOG_W = 22;

   // Register index codes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POWER        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIPPLE_AMPLITUDE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIPPLE_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_RESISTANCE  = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [15:0] SENSITIVITY_RST      = 16'd6554;
   localparam logic [15:0] MIN_POWER_RST        = 16'hB000;
   localparam logic [15:0] RIPPLE_AMPLITUDE_RST = 16'd0;
   localparam logic [15:0] RIPPLE_PERIOD_RST    = 16'd0;
   localparam logic [9:0]  LOAD_RESISTANCE_RST  = 10'd50;

   // 10*log10(2) in Q24, the 2^24 V^2 scale of I^2+Q^2 in Q16 dB-less log2,
   // and the 30 dB offset from watts to dBm in Q16.
   localparam logic [25:0]        TEN_LOG10_2_Q24 = 26'd50504453;
   localparam logic signed [23:0] LOG_BIAS        = 24'sd1572864;
   localparam logic signed [26:0] DBM_OFFSET      = 27'sd1966080;

   // Saturation limits of the output voltage.
   localparam logic signed [26:0] VOLT_MAX = 27'sd8388607;
   localparam logic signed [26:0] VOLT_MIN = -27'sd8388608;

   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // One result as it leaves the datapath.
   typedef struct packed {
      logic signed [23:0] voltage;
      logic               above;
   } result_type;

   // log2(1 + k/2^bits) in Q16 by repeated squaring, rounded to nearest.
   function automatic logic [16:0] log_entry(input int k, input int bits);
      logic [63:0] y;
      logic [31:0] acc;
      int          i;
      y   = ONE_Q30 + (64'(k) << (30 - bits));
      acc = '0;
      if (y >= (64'd1 << 31)) begin
         return 17'd65536;
      end
      for (i = 0; i < 17; i++) begin
         y   = (y * y) >> 30;
         acc = acc << 1;
         if (y >= (64'd1 << 31)) begin
            y   = y >> 1;
            acc = acc | 32'd1;
         end
      end
      return 17'((acc + 32'd1) >> 1);
   endfunction

   // Sine of x in Q30 for 0 <= x <= pi/2, by a nested Taylor series.
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      return (x * t) >> 30;
   endfunction

   // Entry k of a one-period sine table of 2^bits entries, signed Q15.
   function automatic logic signed [15:0] sine_entry(input int k, input int bits);
      int          sh;
      logic [63:0] quad;
      logic [63:0] pos;
      logic [63:0] step;
      logic [63:0] s;
      logic [15:0] mag;
      sh   = bits - 2;
      quad = 64'(k) >> sh;
      pos  = 64'(k) & ((64'd1 << sh) - 64'd1);
      step = quad[0] ? ((64'd1 << sh) - pos) : pos;
      s    = (sin_q30((HALF_PI_Q30 * step) >> sh) + (64'd1 << 14)) >> 15;
      mag  = (s > 64'd32767) ? 16'd32767 : s[15:0];
      return quad[1] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

FILE: rtl/lvd_log2.sv
// Two-lane pipelined log2 unit, Q16 result, five register stages.
// Depends on lvd_pkg for the table function and result width.
module lvd_log2 #(
   parameter int TABLE_BITS = 8,
   parameter int SIDE_W     = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           valid_in,
   input  logic [1:0][31:0]               arg_in,
   input  logic [SIDE_W-1:0]              side_in,
   output logic                           valid_out,
   output logic [1:0][lvd_pkg::LOG_W-1:0] log_out,
   output logic [SIDE_W-1:0]              side_out
);
   import lvd_pkg::*;

   localparam int TAB_N  = 1 << TABLE_BITS;
   localparam int REM_W  = 32 - TABLE_BITS;
   localparam int PROD_W = 17 + REM_W;

   // Interpolation table, one entry more than the segment count.
   logic [16:0] log_tab [TAB_N+1];
   for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
      assign log_tab[g] = log_entry(g, TABLE_BITS);
   end

   logic [4:0]        valid_ff;
   logic [SIDE_W-1:0] side_ff [5];

   // Valid bits and side data move with the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < 5; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign valid_out = valid_ff[4];
   assign side_out  = side_ff[4];

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [31:0]           arg1_ff;
      logic [4:0]            exp1_ff, exp2_ff, exp3_ff, exp4_ff;
      logic [4:0]            exp_in;
      logic [31:0]           norm;
      logic [31:0]           frac;
      logic [TABLE_BITS-1:0] idx2_ff;
      logic [REM_W-1:0]      rem2_ff, rem3_ff;
      logic [TABLE_BITS:0]   lo_idx, hi_idx;
      logic [16:0]           lo3_ff, lo4_ff, diff3_ff;
      logic [PROD_W-1:0]     prod4_ff;
      logic [LOG_W-1:0]      log5_ff;

      // Position of the leading one.
      always_comb begin
         exp_in = '0;
         for (int b = 0; b < 32; b++) begin
            if (arg_in[ln][b]) begin
               exp_in = 5'(b);
            end
         end
      end

      // Normalise so that the leading one drops off the top.
      assign norm   = arg1_ff << (5'd31 - exp1_ff);
      assign frac   = {norm[30:0], 1'b0};
      assign lo_idx = {1'b0, idx2_ff};
      assign hi_idx = lo_idx + 1'b1;

      always_ff @(posedge clock) begin
         if (en) begin
            arg1_ff  <= arg_in[ln];
            exp1_ff  <= exp_in;
            idx2_ff  <= frac[31 -: TABLE_BITS];
            rem2_ff  <= frac[REM_W-1:0];
            exp2_ff  <= exp1_ff;
            lo3_ff   <= log_tab[lo_idx];
            diff3_ff <= log_tab[hi_idx] - log_tab[lo_idx];
            rem3_ff  <= rem2_ff;
            exp3_ff  <= exp2_ff;
            prod4_ff <= PROD_W'(diff3_ff) * PROD_W'(rem3_ff);
            lo4_ff   <= lo3_ff;
            exp4_ff  <= exp3_ff;
            log5_ff  <= {1'b0, exp4_ff, 16'd0} + LOG_W'(lo4_ff)
                        + LOG_W'(prod4_ff[PROD_W-1:REM_W]);
         end
      end

      assign log_out[ln] = log5_ff;
   end

endmodule

FILE: rtl/lvd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side payload and valid bit alongside; no package dependencies.
module lvd_div #(
   parameter int QUO_W  = 24,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  logic [QUO_W-1:0]  num_in,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [QUO_W-1:0]  quo_out,
   output logic [SIDE_W-1:0] side_out
);

   logic [QUO_W-1:0]  valid_ff;
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  num_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  num_prev, quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [DEN_W:0]    trial;
      logic              fits;
      logic [DEN_W-1:0]  rem_in;

      if (s == 0) begin : g_first
         assign rem_prev   = '0;
         assign num_prev   = num_in;
         assign quo_prev   = '0;
         assign side_prev  = side_in;
         assign valid_prev = valid_in;
      end else begin : g_next
         assign rem_prev   = rem_ff[s-1];
         assign num_prev   = num_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign side_prev  = side_ff[s-1];
         assign valid_prev = valid_ff[s-1];
      end

      // Bring down one numerator bit and try the subtraction.
      assign trial  = {rem_prev, num_prev[QUO_W-1]};
      assign fits   = trial >= {1'b0, den};
      assign rem_in = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            num_ff[s]  <= {num_prev[QUO_W-2:0], 1'b0};
            quo_ff[s]  <= {quo_prev[QUO_W-2:0], fits};
            side_ff[s] <= side_prev;
         end
      end
   end

   assign valid_out = valid_ff[QUO_W-1];
   assign quo_out   = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

FILE: rtl/lvd_outbuf.sv
// Output register with a one-entry skid stage for the result channel.
// Depends on lvd_pkg for the result type.
module lvd_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lvd_pkg::result_type in_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lvd_pkg::result_type rsp_data
);
   import lvd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;
   logic       load;

   assign take = out_valid_ff && !rsp_stall;
   assign load = in_valid && !skid_valid_ff;

   // The skid entry drains first; new results go straight out when possible.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end else begin
         // Nothing arrives and nothing leaves, so both entries keep their contents.
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: rtl/log_video_detector.sv
// Logarithmic video detector: turns each I/Q envelope sample into a detector voltage
// from its power in dBm. Built on lvd_pkg, lvd_log2, lvd_div and lvd_outbuf.
//
// The block takes one sample per clock and returns one result per sample, in order.
// A sample passes through the squares and I^2+Q^2, the log2 unit, the dB scaling and
// floor compare, the divider that finds the ripple phase, the sine lookup and ripple
// product, and the output register. The pipeline holds only when a result sits in the
// output register and another in the skid stage behind it; req_stall then stays high
// until the result side takes one. Configuration writes are always ready and must be
// made while no sample is in flight.
module log_video_detector #(
   parameter int LOG_TABLE_BITS  = 8,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [15:0]             req_in_phase,
   input  logic signed [15:0]             req_quadrature,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [23:0]             rsp_detector_voltage,
   output logic                           rsp_above_floor,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lvd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_data
);
   import lvd_pkg::*;

   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam int QUO_W  = 16 + SINE_TABLE_BITS;
   localparam int ACC_W  = 40;
   localparam int SIDE_W = ACC_W + 1;

   // Configuration registers.
   logic [15:0]        sens_ff;
   logic signed [15:0] min_pwr_ff;
   logic signed [15:0] amp_ff;
   logic [15:0]        period_ff;
   logic [9:0]         load_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff    <= SENSITIVITY_RST;
         min_pwr_ff <= MIN_POWER_RST;
         amp_ff     <= RIPPLE_AMPLITUDE_RST;
         period_ff  <= RIPPLE_PERIOD_RST;
         load_ff    <= LOAD_RESISTANCE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SENSITIVITY:      sens_ff    <= csr_data;
            CSR_MIN_POWER:        min_pwr_ff <= csr_data;
            CSR_RIPPLE_AMPLITUDE: amp_ff     <= csr_data;
            CSR_RIPPLE_PERIOD:    period_ff  <= csr_data;
            CSR_LOAD_RESISTANCE:  load_ff    <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // Ripple gain is registered from the configuration registers; it is settled long before use.
   logic signed [32:0] ripple_gain_ff;
   always_ff @(posedge clock) begin
      ripple_gain_ff <= $signed({1'b0, sens_ff}) * amp_ff;
   end

   // Sine table over one period.
   logic signed [15:0] sine_tab [SINE_N];
   for (genvar g = 0; g < SINE_N; g++) begin : g_sine
      assign sine_tab[g] = sine_entry(g, SINE_TABLE_BITS);
   end

   logic       en;
   logic       out_full;
   result_type result_in;

   assign en        = !out_full;
   assign req_stall = out_full;

   // Stage 1 and 2: squares, then I^2+Q^2.
   logic               v1_ff, v2_ff;
   logic signed [31:0] sq_i, sq_q;
   logic [30:0]        sq_i_ff, sq_q_ff;
   logic [31:0]        pwr_ff;

   assign sq_i = req_in_phase * req_in_phase;
   assign sq_q = req_quadrature * req_quadrature;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_i_ff <= sq_i[30:0];
         sq_q_ff <= sq_q[30:0];
         pwr_ff  <= {1'b0, sq_i_ff} + {1'b0, sq_q_ff};
      end
   end

   // Log2 of the power and of twice the load (a zero load counts as one ohm).
   logic [9:0]             load_eff;
   logic [1:0][31:0]       log_arg;
   logic [1:0][LOG_W-1:0]  log_res;
   logic                   log_valid;
   logic                   log_nz;

   assign load_eff   = (load_ff == '0) ? 10'd1 : load_ff;
   assign log_arg[0] = pwr_ff;
   assign log_arg[1] = {21'd0, load_eff, 1'b0};

   lvd_log2 #(
      .TABLE_BITS (LOG_TABLE_BITS),
      .SIDE_W     (1)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v2_ff),
      .arg_in    (log_arg),
      .side_in   (pwr_ff != '0),
      .valid_out (log_valid),
      .log_out   (log_res),
      .side_out  (log_nz)
   );

   // Stages 3 to 5: log difference, scaling to dB, offset and floor compare.
   logic               v3_ff, v4_ff, v5_ff;
   logic               nz3_ff, nz4_ff, above5_ff;
   logic signed [23:0] diff_ff;
   logic signed [50:0] db_prod_ff;
   logic signed [26:0] pa;
   logic signed [27:0] excess;
   logic               above_in;
   logic [23:0]        excess_ff;

   assign pa       = $signed(db_prod_ff[50:24]) + DBM_OFFSET;
   assign excess   = 28'(pa) - 28'($signed({min_pwr_ff, 8'd0}));
   assign above_in = nz4_ff && !excess[27] && (excess != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= log_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff    <= $signed({2'b00, log_res[0]}) - $signed({2'b00, log_res[1]}) - LOG_BIAS;
         nz3_ff     <= log_nz;
         db_prod_ff <= diff_ff * $signed({1'b0, TEN_LOG10_2_Q24});
         nz4_ff     <= nz3_ff;
         excess_ff  <= excess[23:0];
         above5_ff  <= above_in;
      end
   end

   // Ripple phase: floor(excess * 2^bits / (period * 256)), pipelined.
   logic [24+SINE_TABLE_BITS-1:0] num_wide;
   logic [QUO_W-1:0]              quo;
   logic [ACC_W-1:0]              base_acc;
   logic [SIDE_W-1:0]             div_side;
   logic                          div_valid;

   assign num_wide = {excess_ff, {SINE_TABLE_BITS{1'b0}}};
   assign base_acc = ACC_W'(sens_ff) * ACC_W'(excess_ff);

   lvd_div #(
      .QUO_W  (QUO_W),
      .DEN_W  (16),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v5_ff),
      .num_in    (num_wide[24+SINE_TABLE_BITS-1:8]),
      .den       (period_ff),
      .side_in   ({base_acc, above5_ff}),
      .valid_out (div_valid),
      .quo_out   (quo),
      .side_out  (div_side)
   );

   // Stages 6 and 7: sine lookup, then ripple product.
   logic               v6_ff, v7_ff;
   logic signed [15:0] sine_ff;
   logic [ACC_W-1:0]   acc6_ff, acc7_ff;
   logic               above6_ff, above7_ff;
   logic signed [48:0] ripple_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= div_valid;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff   <= (period_ff == '0) ? 16'sd0 : sine_tab[quo[SINE_TABLE_BITS-1:0]];
         acc6_ff   <= div_side[SIDE_W-1:1];
         above6_ff <= div_side[0];
         ripple_ff <= ripple_gain_ff * sine_ff;
         acc7_ff   <= acc6_ff;
         above7_ff <= above6_ff;
      end
   end

   // Final sum, scale to Q16 volts and saturate.
   logic signed [42:0] total;
   logic signed [26:0] volts;

   assign total = $signed({3'b000, acc7_ff}) + 43'($signed(ripple_ff[48:7]));
   assign volts = total[42:16];

   always_comb begin
      result_in.above = above7_ff;
      priority if (!above7_ff) begin
         result_in.voltage = '0;
      end else if (volts > VOLT_MAX) begin
         result_in.voltage = VOLT_MAX[23:0];
      end else if (volts < VOLT_MIN) begin
         result_in.voltage = VOLT_MIN[23:0];
      end else begin
         result_in.voltage = volts[23:0];
      end
   end

   result_type rsp_data;

   lvd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_data   (result_in),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_detector_voltage = rsp_data.voltage;
   assign rsp_above_floor      = rsp_data.above;

   // The skid stage only fills behind a waiting result.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      out_full |-> rsp_valid)
      else $error("skid stage holds a result while the output register is empty");

   // The input side is only held off after a result transfer was refused.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a refused result transfer");

   // Results at or below the floor carry zero volts.
   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_above_floor) |-> (rsp_detector_voltage == '0))
      else $error("non-zero voltage reported below the floor");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for log_video_detector: directed and random I/Q samples,
// register sweeps and receiver hold-off, checked against an in-bench bit-true predictor.
// Depends on lvd_pkg and the log_video_detector RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lvd_pkg::*;

   localparam int LOG_BITS  = 8;
   localparam int SINE_BITS = 8;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 5000;
   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam longint unsigned HALF_PI = 64'd1686629713;

   typedef struct {
      logic signed [23:0] voltage;
      logic               above;
   } detection_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_in_phase;
   logic signed [15:0] req_quadrature;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [23:0] rsp_detector_voltage;
   logic rsp_above_floor;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_data;

   // Predictor copy of the registers and its fixed tables.
   longint          gain;
   longint          floor_q8;
   longint          ripple_amp;
   longint          ripple_len;
   longint          load_ohms;
   longint unsigned log2_lut [0:(1<<LOG_BITS)];
   longint          sine_lut [0:(1<<SINE_BITS)-1];

   detection_type pending_q[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  calm = 0;
   bit  hold_ask = 0;
   bit  hold_seen = 0;
   int  hold_left = 0;

   log_video_detector #(.LOG_TABLE_BITS(LOG_BITS), .SINE_TABLE_BITS(SINE_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_phase(req_in_phase), .req_quadrature(req_quadrature),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_detector_voltage(rsp_detector_voltage), .rsp_above_floor(rsp_above_floor),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sine of a Q30 angle in the first quadrant, nested series.
   function automatic longint unsigned series_sine(input longint unsigned ang);
      longint unsigned sq;
      longint unsigned term;
      longint unsigned dv [5];
      dv = '{110, 72, 42, 20, 6};
      sq = (ang * ang) >> 30;
      term = Q30;
      foreach (dv[n]) term = Q30 - (((sq * term) >> 30) / dv[n]);
      return (ang * term) >> 30;
   endfunction

   function automatic longint quarter_sine(input longint unsigned step, input longint quarter);
      longint unsigned s;
      s = (series_sine((HALF_PI * step) / quarter) + (64'd1 << 14)) >> 15;
      return (s > 32767) ? 32767 : longint'(s);
   endfunction

   // Fill the log2 and sine tables the way the hardware fills them.
   function automatic void fill_tables();
      longint unsigned y;
      longint unsigned acc;
      longint quarter;
      longint mag;
      quarter = (1 << SINE_BITS) / 4;
      for (int k = 0; k <= (1 << LOG_BITS); k++) begin
         y = Q30 + (longint'(k) << (30 - LOG_BITS));
         acc = 0;
         if (y >= (64'd1 << 31)) begin
            log2_lut[k] = 65536;
         end else begin
            for (int n = 0; n < 17; n++) begin
               y = (y * y) >> 30;
               acc = acc << 1;
               if (y >= (64'd1 << 31)) begin
                  y = y >> 1;
                  acc = acc | 1;
               end
            end
            log2_lut[k] = (acc + 1) >> 1;
         end
      end
      for (int k = 0; k < (1 << SINE_BITS); k++) begin
         if ((k / quarter) % 2 == 1) mag = quarter_sine(quarter - k % quarter, quarter);
         else mag = quarter_sine(k % quarter, quarter);
         sine_lut[k] = ((k / quarter) >= 2) ? -mag : mag;
      end
   endfunction

   // log2 in Q16 with table interpolation.
   function automatic longint log2_fixed(input longint unsigned v);
      int e;
      longint unsigned frac;
      longint unsigned rem;
      longint unsigned lo;
      longint unsigned hi;
      int k;
      e = 0;
      while (e < 31 && (v >> (e + 1)) != 0) e++;
      frac = (v << (32 - e)) & 64'hFFFF_FFFF;
      k = int'(frac >> (32 - LOG_BITS));
      rem = frac & ((64'd1 << (32 - LOG_BITS)) - 1);
      lo = log2_lut[k];
      hi = log2_lut[k + 1];
      return longint'(e) * 65536 + longint'(lo) + longint'(((hi - lo) * rem) >> (32 - LOG_BITS));
   endfunction

   // Detector voltage and floor flag of one envelope sample.
   function automatic detection_type detect(input logic signed [15:0] ip,
                                            input logic signed [15:0] qp);
      detection_type res;
      longint pwr;
      longint ohms;
      longint dlog;
      longint pa;
      longint excess;
      longint acc;
      longint phase;
      res.voltage = '0;
      res.above = 1'b0;
      pwr = longint'(ip) * ip + longint'(qp) * qp;
      ohms = (load_ohms == 0) ? 1 : load_ohms;
      if (pwr == 0) return res;
      dlog = log2_fixed(pwr) - log2_fixed(2 * ohms) - (longint'(24) << 16);
      pa = ((dlog * 50504453) >>> 24) + (longint'(30) << 16);
      excess = pa - floor_q8 * 256;
      if (excess <= 0) return res;
      acc = gain * excess;
      if (ripple_len != 0) begin
         phase = ((excess << SINE_BITS) / (ripple_len << 8)) & ((1 << SINE_BITS) - 1);
         acc += (gain * ripple_amp * sine_lut[phase]) >>> 7;
      end
      acc = acc >>> 16;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      res.voltage = acc[23:0];
      res.above = 1'b1;
      return res;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      case (idx)
         CSR_SENSITIVITY: begin
            gain = longint'(val);
         end
         CSR_MIN_POWER: begin
            floor_q8 = longint'($signed(val));
         end
         CSR_RIPPLE_AMPLITUDE: begin
            ripple_amp = longint'($signed(val));
         end
         CSR_RIPPLE_PERIOD: begin
            ripple_len = longint'(val);
         end
         CSR_LOAD_RESISTANCE: begin
            load_ohms = longint'(val[9:0]);
         end
         default: begin
         end
      endcase
   endfunction

   // Result side: check each transfer, then choose the next stall.
   always @(posedge clock) begin
      detection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result: detector_voltage %0d above_floor %0d",
                   rsp_detector_voltage, rsp_above_floor);
            mismatches++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_detector_voltage !== want.voltage) begin
               $error("detector_voltage: expected %0d, got %0d",
                      want.voltage, rsp_detector_voltage);
               mismatches++;
            end
            if (rsp_above_floor !== want.above) begin
               $error("above_floor: expected %0d, got %0d", want.above, rsp_above_floor);
               mismatches++;
            end
         end
      end
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one sample; valid stays high afterwards until an idle cycle or the end.
   task automatic send_sample(input logic signed [15:0] ip, input logic signed [15:0] qp);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_phase <= ip;
      req_quadrature <= qp;
      do @(posedge clock); while (req_stall);
      pending_q.push_back(detect(ip, qp));
   endtask

   // Wait for the pipeline to empty before touching a register.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] sens, input logic [15:0] floor_v,
                            input logic [15:0] amp, input logic [15:0] period,
                            input logic [15:0] ohms);
      drain();
      write_reg(CSR_SENSITIVITY, sens);
      write_reg(CSR_MIN_POWER, floor_v);
      write_reg(CSR_RIPPLE_AMPLITUDE, amp);
      write_reg(CSR_RIPPLE_PERIOD, period);
      write_reg(CSR_LOAD_RESISTANCE, ohms);
   endtask

   function automatic logic signed [15:0] rand_field();
      case ($urandom_range(3))
         0: return $signed(16'($urandom_range(65535)));
         1: return $signed(16'($urandom_range(64))) - 16'sd32;
         2: return $signed(16'($urandom_range(2047))) - 16'sd1024;
         default: return $signed(16'($urandom_range(16383))) - 16'sd8192;
      endcase
   endfunction

   // Reset values, then zero input, field extremes and the floor boundary.
   task automatic test_reset_defaults();
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(-16'sd32768, -16'sd32768);
      send_sample(-16'sd32768, 16'sd0);
      send_sample(16'sd0, 16'sh7FFF);
      send_sample(16'sd1, 16'sd0);
      send_sample(16'sd0, -16'sd1);
      send_sample(16'sd4096, 16'sd0);
      send_sample(16'sd12, 16'sd5);
   endtask

   // Ripple on, inverted ripple, zero and maximum load, saturation and ignored indexes.
   task automatic test_special_settings();
      configure(16'd6554, 16'hB000, 16'd768, 16'd2560, 16'd50);
      send_sample(16'sd4096, 16'sd1000);
      send_sample(16'sd300, -16'sd200);
      configure(16'd6554, 16'hB000, -16'sd768, 16'd1, 16'd0);
      send_sample(16'sd4096, 16'sd1000);
      send_sample(16'sd2, 16'sd3);
      configure(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd1023);
      send_sample(16'sh7FFF, -16'sd32768);
      send_sample(16'sd1, 16'sd1);
      configure(16'hFFFF, 16'h8000, 16'h8000, 16'd256, 16'd1);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sd100, 16'sd0);
      configure(16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd1023);
      send_sample(16'sh7FFF, 16'sh7FFF);
      drain();
      write_reg(3'd5, 16'hFFFF);
      write_reg(3'd7, 16'h1234);
      send_sample(16'sh7FFF, 16'sh7FFF);
   endtask

   // Random samples under a random register setting, with or without idling.
   task automatic test_random_phase(input int count, input bit quiet);
      logic [15:0] ohms;
      ohms = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                       : 16'($urandom_range(200));
      configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)),
                ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535)), ohms);
      calm = quiet;
      repeat (count) send_sample(rand_field(), rand_field());
      calm = 1'b0;
   endtask

   // Long hold-off on the result side while samples keep coming.
   task automatic test_backpressure();
      calm = 1'b1;
      hold_ask = ~hold_ask;
      repeat (150) send_sample(rand_field(), rand_field());
      calm = 1'b0;
   endtask

   initial begin
      fill_tables();
      gain = 6554;
      floor_q8 = -20480;
      ripple_amp = 0;
      ripple_len = 0;
      load_ohms = 50;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_phase <= '0;
      req_quadrature <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_special_settings();
      test_random_phase(150, 1'b1);
      test_backpressure();
      for (int n = 0; n < 10; n++) test_random_phase(140, 1'b0);

      drain();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
